### hw/rtl/sgt_pkg.sv
// ----------------------------------------------------------------------------
// sgt_pkg: shared types and constants for the stack graph traversal block
// Item structs, request codes, sequencer states and sizing constants.
// ----------------------------------------------------------------------------
package sgt_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VIDX_W       = 6;   // vertex index field width
  localparam int COUNT_W      = 7;   // vertex count and stack depth width

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_RUN   = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [VIDX_W-1:0] from_vertex;
    logic [VIDX_W-1:0] to_vertex;
  } in_item_t;

  typedef struct packed {
    logic [VIDX_W-1:0] visited_vertex;
    logic              last;
    logic              bad_start;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_POP,
    ST_ROW,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

### hw/rtl/sgt_ram.sv
// ----------------------------------------------------------------------------
// sgt_ram: generic single-write, single-read RAM
// One write port and one read port with enable; read data is registered.
// ----------------------------------------------------------------------------
module sgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/stack_graph_traversal.sv
// Sequencing: clear is done in idle; add edge does a row read, then a write back.
// Run: a bad start goes straight to its item; otherwise each visited vertex
//   takes a stack pop and a row read, then the neighbour scan over every vertex in
//   use through the shared scan step, then the hand-over of its item.
// Throughput: one item at a time; in_ready is low until the sequencer is idle.
// Reset (rst, synchronous): empty graph, vertex_count 64, no item pending.
// ----------------------------------------------------------------------------
// stack_graph_traversal: depth-first graph traversal with an explicit stack
// Adjacency rows and the pending stack live in RAMs; a small sequencer pops,
// fetches a row and scans it one neighbour per cycle.
// ----------------------------------------------------------------------------
module stack_graph_traversal (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sgt_pkg::COUNT_W-1:0]       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sgt_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sgt_pkg::out_item_t                out_data
);

  import sgt_pkg::*;

  state_t state, state_next;

  logic [COUNT_W-1:0]      vcount;
  logic [COUNT_W-1:0]      eff_n;
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] seen;
  logic [COUNT_W-1:0]      depth;
  logic [VIDX_W-1:0]       cur;
  logic [VIDX_W-1:0]       scan_v;
  logic [VIDX_W-1:0]       add_from;
  logic [VIDX_W-1:0]       add_to;
  out_item_t               res;

  logic                    in_fire;
  logic                    bad_run;
  logic                    emit_fire;
  logic                    scan_end;
  logic                    push;

  logic                    adj_we, adj_re;
  logic [VIDX_W-1:0]       adj_waddr, adj_raddr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
  logic                    stk_we, stk_re;
  logic [VIDX_W-1:0]       stk_waddr, stk_raddr;
  logic [VIDX_W-1:0]       stk_wdata, stk_rdata;

  sgt_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
    .clk  (clk),
    .we   (adj_we),
    .waddr(adj_waddr),
    .wdata(adj_wdata),
    .re   (adj_re),
    .raddr(adj_raddr),
    .rdata(adj_rdata)
  );

  sgt_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_VERTICES)) u_stack (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .re   (stk_re),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  assign eff_n     = (vcount > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES) : vcount;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign bad_run   = {1'b0, in_data.from_vertex} >= eff_n;
  assign emit_fire = !out_valid || out_ready;
  assign scan_end  = ({1'b0, scan_v} == (eff_n - COUNT_W'(1)));
  // A row that has not been written since the last clear reads as empty.
  assign push      = row_valid[cur] && adj_rdata[scan_v] && !seen[scan_v];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.req_type)
            REQ_ADD: state_next = ST_ADD_WR;
            REQ_RUN: state_next = bad_run ? ST_EMIT : ST_POP;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD_WR: state_next = ST_IDLE;
      ST_POP:    state_next = ST_ROW;
      ST_ROW:    state_next = ST_SCAN;
      ST_SCAN:   state_next = scan_end ? ST_EMIT : ST_SCAN;
      ST_EMIT: begin
        if (emit_fire) begin
          state_next = res.last ? ST_IDLE : ST_POP;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = add_from;
    adj_wdata = (row_valid[add_from] ? adj_rdata : '0) | (MAX_VERTICES'(1) << add_to);
    adj_re    = 1'b0;
    adj_raddr = in_data.from_vertex;
    stk_we    = 1'b0;
    stk_waddr = depth[VIDX_W-1:0];
    stk_wdata = scan_v;
    stk_re    = 1'b0;
    stk_raddr = depth[VIDX_W-1:0] - VIDX_W'(1);
    case (state)
      ST_IDLE: begin
        if (in_fire && in_data.req_type == REQ_ADD) begin
          adj_re = 1'b1;
        end
        if (in_fire && in_data.req_type == REQ_RUN && !bad_run) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = in_data.from_vertex;
        end
      end
      ST_ADD_WR: adj_we = 1'b1;
      ST_POP:    stk_re = 1'b1;
      ST_ROW: begin
        adj_re    = 1'b1;
        adj_raddr = stk_rdata;
      end
      ST_SCAN:   stk_we = push;
      ST_EMIT:   ;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vcount    <= COUNT_W'(MAX_VERTICES);
      row_valid <= '0;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        vcount <= cfg_wdata;
      end
      if (emit_fire && state == ST_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire && in_data.req_type == REQ_CLEAR) begin
            row_valid <= '0;
          end
          if (in_fire && in_data.req_type == REQ_RUN && !bad_run) begin
            depth <= COUNT_W'(1);
          end
        end
        ST_ADD_WR: row_valid[add_from] <= 1'b1;
        ST_POP:    depth <= depth - COUNT_W'(1);
        ST_SCAN: begin
          if (push) begin
            depth <= depth + COUNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && emit_fire) begin
      out_data <= res;
    end
    case (state)
      ST_IDLE: begin
        add_from <= in_data.from_vertex;
        add_to   <= in_data.to_vertex;
        if (in_fire && in_data.req_type == REQ_RUN) begin
          seen          <= MAX_VERTICES'(1) << in_data.from_vertex;
          res.visited_vertex <= '0;
          res.last      <= 1'b1;
          res.bad_start <= 1'b1;
        end
      end
      ST_ROW: begin
        cur                <= stk_rdata;
        scan_v             <= '0;
        res.visited_vertex <= stk_rdata;
        res.bad_start      <= 1'b0;
      end
      ST_SCAN: begin
        scan_v <= scan_v + VIDX_W'(1);
        if (push) begin
          seen[scan_v] <= 1'b1;
        end
        if (scan_end) begin
          res.last <= !push && (depth == '0);
        end
      end
      default: ;
    endcase
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= COUNT_W'(MAX_VERTICES))
    else $error("stack depth beyond capacity");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_POP |-> depth != '0)
    else $error("pop from an empty stack");

  a_cur_seen: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> seen[cur])
    else $error("scanned vertex not marked seen");

  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bad_start |-> out_data.last && out_data.visited_vertex == '0)
    else $error("bad start item malformed");

endmodule
